// ===== sv/iirbq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirbq_pkg: shared types and constants of the seeded DF2T IIR filter
// Field widths, fixed-point positions, register indexes, reset values,
// sequencer states and the per-phase strobes that drive the cells.
// ----------------------------------------------------------------------------
package iirbq_pkg;

    localparam int DATA_W     = 32;   // Q16.16 samples and results
    localparam int COEF_W     = 32;   // Q2.30 coefficients, Q8.24 reciprocal
    localparam int STATE_W    = 40;   // Q24.16 delay state
    localparam int SEED_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int COEF_FRAC  = 30;
    localparam int RECIP_FRAC = 24;
    localparam int PROD_W     = COEF_W + DATA_W;
    localparam int TERM_W     = PROD_W - COEF_FRAC;   // a product scaled to Q.16
    localparam int ACC_W      = STATE_W + 1;

    localparam int ORDER_DEF  = 2;

    localparam logic signed [COEF_W-1:0] B0_RESET    = 32'sh4000_0000;
    localparam logic signed [COEF_W-1:0] RECIP_RESET = 32'sh0100_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0,
        CFG_B1,
        CFG_B2,
        CFG_A1,
        CFG_A2,
        CFG_RECIP,
        CFG_SEED
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULX,
        ST_ACC,
        ST_MULR,
        ST_FB,
        ST_MULY,
        ST_UPD,
        ST_HOLD
    } seq_state_t;

    typedef struct packed {
        logic clear;   // zero the delay state
        logic mul_x;   // coefficient times sample
        logic acc;     // form the accumulator from the first state
        logic mul_r;   // accumulator times reciprocal
        logic fb;      // saturate and register the output
        logic mul_y;   // feedback coefficient times output
        logic upd;     // write the new delay state
    } pass_ctrl_t;

endpackage

// ===== sv/iirbq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirbq_cell: one delay element of the transposed structure
// Holds one state word and takes the next word from its neighbor in the row.
// One multiplier forms the numerator term and then the feedback term.
// ----------------------------------------------------------------------------
module iirbq_cell
    import iirbq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pass_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0]  x,
    input  logic signed [DATA_W-1:0]  y,
    input  logic signed [COEF_W-1:0]  coef_b,
    input  logic signed [COEF_W-1:0]  coef_a,
    input  logic signed [STATE_W-1:0] s_in,
    output logic signed [STATE_W-1:0] s_out
);

    localparam int SUM_W = STATE_W + 2;
    localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(40'sh7F_FFFF_FFFF);
    localparam logic signed [SUM_W-1:0] S_MIN = SUM_W'(40'sh80_0000_0000);

    logic signed [COEF_W-1:0]  op_c;
    logic signed [DATA_W-1:0]  op_v;
    logic signed [PROD_W-1:0]  prod;
    logic signed [TERM_W-1:0]  bx_reg;
    logic signed [TERM_W-1:0]  ay_reg;
    logic signed [STATE_W-1:0] s_reg;
    logic signed [SUM_W-1:0]   s_sum;
    logic signed [STATE_W-1:0] s_next;

    assign op_c = ctrl.mul_y ? coef_a : coef_b;
    assign op_v = ctrl.mul_y ? y : x;
    assign prod = op_c * op_v;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_x)
        begin
            bx_reg <= prod[PROD_W-1:COEF_FRAC];
        end
        if (ctrl.mul_y)
        begin
            ay_reg <= prod[PROD_W-1:COEF_FRAC];
        end
    end

    // New state is the neighbor's old state plus this tap's terms, saturated.
    always_comb
    begin
        s_sum = SUM_W'(s_in) + SUM_W'(bx_reg) - SUM_W'(ay_reg);
        if (s_sum > S_MAX)
        begin
            s_next = S_MAX[STATE_W-1:0];
        end
        else if (s_sum < S_MIN)
        begin
            s_next = S_MIN[STATE_W-1:0];
        end
        else
        begin
            s_next = s_sum[STATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            s_reg <= '0;
        end
        else if (ctrl.upd)
        begin
            s_reg <= s_next;
        end
    end

    assign s_out = s_reg;

endmodule

// ===== sv/iirbq_head.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirbq_head: output end of the filter
// Forms b0*x plus the first state, scales it by the reciprocal of a0 as a
// split high/low product and saturates the output to 32 bits.
// ----------------------------------------------------------------------------
module iirbq_head
    import iirbq_pkg::*;
(
    input  logic                      clk,
    input  pass_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0]  x,
    input  logic signed [COEF_W-1:0]  coef_b0,
    input  logic signed [COEF_W-1:0]  recip,
    input  logic signed [STATE_W-1:0] s0,
    output logic signed [DATA_W-1:0]  y
);

    localparam int HI_W  = ACC_W - RECIP_FRAC;
    localparam int HIP_W = HI_W + COEF_W;
    localparam int LO_W  = RECIP_FRAC + 1;
    localparam int LOP_W = LO_W + COEF_W;
    localparam int LOS_W = LOP_W - RECIP_FRAC;
    localparam int YS_W  = HIP_W + 1;
    localparam logic signed [YS_W-1:0] Y_MAX = YS_W'(32'sh7FFF_FFFF);
    localparam logic signed [YS_W-1:0] Y_MIN = YS_W'(32'sh8000_0000);

    logic signed [PROD_W-1:0] b0x_prod;
    logic signed [TERM_W-1:0] b0x_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [HI_W-1:0]   acc_hi;
    logic signed [LO_W-1:0]   acc_lo;
    logic signed [HIP_W-1:0]  hi_prod;
    logic signed [LOP_W-1:0]  lo_prod;
    logic signed [HIP_W-1:0]  hi_prod_reg;
    logic signed [LOS_W-1:0]  lo_sh_reg;
    logic signed [YS_W-1:0]   y_sum;
    logic signed [DATA_W-1:0] y_next;
    logic signed [DATA_W-1:0] y_reg;

    assign b0x_prod = coef_b0 * x;

    // The low part is unsigned, so the two products add up to acc * recip.
    assign acc_hi  = acc_reg[ACC_W-1:RECIP_FRAC];
    assign acc_lo  = {1'b0, acc_reg[RECIP_FRAC-1:0]};
    assign hi_prod = acc_hi * recip;
    assign lo_prod = acc_lo * recip;

    always_comb
    begin
        y_sum = YS_W'(hi_prod_reg) + YS_W'(lo_sh_reg);
        if (y_sum > Y_MAX)
        begin
            y_next = Y_MAX[DATA_W-1:0];
        end
        else if (y_sum < Y_MIN)
        begin
            y_next = Y_MIN[DATA_W-1:0];
        end
        else
        begin
            y_next = y_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_x)
        begin
            b0x_reg <= b0x_prod[PROD_W-1:COEF_FRAC];
        end
        if (ctrl.acc)
        begin
            acc_reg <= ACC_W'(s0) + ACC_W'(b0x_reg);
        end
        if (ctrl.mul_r)
        begin
            hi_prod_reg <= hi_prod;
            lo_sh_reg   <= lo_prod[LOP_W-1:RECIP_FRAC];
        end
        if (ctrl.fb)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== sv/iir_biquad_df2t_seeded_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_biquad_df2t_seeded_core: seeded fixed-point IIR filter, DF2T form
// A row of delay cells behind an output head, run by a six-phase sequencer.
// ----------------------------------------------------------------------------
// Usage:
// Input items (item_valid / item_stall) carry a Q16.16 sample and a restart
// flag. A restart item clears the delay state, re-arms seeding and gives no
// result, and the sequencer stays idle. Any other item runs one filter
// pass of six phases: b*x products, accumulate, reciprocal products,
// output saturation, feedback products, state update. The sequencer walks
// these phases; each cell holds one delay word and reads its neighbor's word.
// On the first sample after reset or a restart, seed_count extra passes run
// on that same sample before the pass that gives the result. A new item is
// taken only while idle, once the previous item's result has been loaded into
// the output register. Results leave through an output register
// (filt_valid / filt_stall); while it holds an untaken result the core
// still accepts and works on the next item, and only waits at the end of
// that item's last pass.
// Configuration writes (cfg_valid / cfg_ready, always ready) set the
// coefficients, the reciprocal of a0 and seed_count; write only when idle.
// Reset gives b0 = 1.0, 1/a0 = 1.0, other registers zero, a zero state,
// seeding armed and an empty output register.
// ----------------------------------------------------------------------------
module iir_biquad_df2t_seeded_core
    import iirbq_pkg::*;
#(
    parameter int ORDER = ORDER_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     restart,
    output logic                     filt_valid,
    input  logic                     filt_stall,
    output logic signed [DATA_W-1:0] filtered,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]        cfg_data
);

    // Configuration registers.
    logic signed [COEF_W-1:0] coef_b0_reg;
    logic signed [COEF_W-1:0] coef_b1_reg;
    logic signed [COEF_W-1:0] coef_b2_reg;
    logic signed [COEF_W-1:0] coef_a1_reg;
    logic signed [COEF_W-1:0] coef_a2_reg;
    logic signed [COEF_W-1:0] recip_reg;
    logic [SEED_W-1:0]        seed_count_reg;

    // Sequencer state.
    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [SEED_W-1:0] seed_rem_reg;
    logic [SEED_W-1:0] seed_rem_next;
    logic              first_pending_reg;
    logic              first_pending_next;
    pass_ctrl_t        ctrl;
    logic              item_accept;
    logic              x_load;
    logic              out_load;
    logic              out_free;

    // Datapath.
    logic signed [DATA_W-1:0]  x_reg;
    logic signed [DATA_W-1:0]  y;
    logic signed [STATE_W-1:0] s_chain [ORDER+1];
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg    <= B0_RESET;
            coef_b1_reg    <= '0;
            coef_b2_reg    <= '0;
            coef_a1_reg    <= '0;
            coef_a2_reg    <= '0;
            recip_reg      <= RECIP_RESET;
            seed_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Indexes past the register list are dropped.
            unique case (cfg_index)
                CFG_B0:    coef_b0_reg    <= cfg_data;
                CFG_B1:    coef_b1_reg    <= cfg_data;
                CFG_B2:    coef_b2_reg    <= cfg_data;
                CFG_A1:    coef_a1_reg    <= cfg_data;
                CFG_A2:    coef_a2_reg    <= cfg_data;
                CFG_RECIP: recip_reg      <= cfg_data;
                CFG_SEED:  seed_count_reg <= cfg_data[SEED_W-1:0];
                default:   ;
            endcase
        end
    end

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign out_free    = !out_valid_reg || !filt_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            seed_rem_reg      <= '0;
            first_pending_reg <= 1'b1;
        end
        else
        begin
            state_reg         <= state_next;
            seed_rem_reg      <= seed_rem_next;
            first_pending_reg <= first_pending_next;
        end
    end

    // One pass runs MULX through UPD. At the end of a pass the seeding
    // counter decides between another pass and delivering the result.
    always_comb
    begin
        state_next         = state_reg;
        seed_rem_next      = seed_rem_reg;
        first_pending_next = first_pending_reg;
        ctrl               = '0;
        x_load             = 1'b0;
        out_load           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (restart)
                    begin
                        ctrl.clear         = 1'b1;
                        first_pending_next = 1'b1;
                        seed_rem_next      = '0;
                    end
                    else
                    begin
                        x_load             = 1'b1;
                        first_pending_next = 1'b0;
                        seed_rem_next      = first_pending_reg ? seed_count_reg : '0;
                        state_next         = ST_MULX;
                    end
                end
            end
            ST_MULX:
            begin
                ctrl.mul_x = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                ctrl.acc   = 1'b1;
                state_next = ST_MULR;
            end
            ST_MULR:
            begin
                ctrl.mul_r = 1'b1;
                state_next = ST_FB;
            end
            ST_FB:
            begin
                ctrl.fb    = 1'b1;
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                ctrl.mul_y = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                ctrl.upd = 1'b1;
                if (seed_rem_reg != '0)
                begin
                    seed_rem_next = seed_rem_reg - 1'b1;
                    state_next    = ST_MULX;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (x_load)
        begin
            x_reg <= sample;
        end
        if (out_load)
        begin
            out_data_reg <= y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!filt_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign filt_valid = out_valid_reg;
    assign filtered   = out_data_reg;

    // The last cell sees a zero neighbor; cell i uses b[i+1] and a[i+1].
    assign s_chain[ORDER] = '0;

    for (genvar i = 0; i < ORDER; i++)
    begin : g_cell
        localparam int TAP = i + 1;
        iirbq_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .x      (x_reg),
            .y      (y),
            .coef_b ((TAP == 1) ? coef_b1_reg : coef_b2_reg),
            .coef_a ((TAP == 1) ? coef_a1_reg : coef_a2_reg),
            .s_in   (s_chain[i+1]),
            .s_out  (s_chain[i])
        );
    end

    iirbq_head u_head
    (
        .clk     (clk),
        .ctrl    (ctrl),
        .x       (x_reg),
        .coef_b0 (coef_b0_reg),
        .recip   (recip_reg),
        .s0      (s_chain[0]),
        .y       (y)
    );

    // A result only appears at the end of a final pass.
    a_result_from_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(filt_valid) |-> ($past(state_reg) == ST_UPD || $past(state_reg) == ST_HOLD))
        else $error("result appeared outside the end of a pass");

    // A restart item never produces a result.
    a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && restart) |=> !$rose(filt_valid))
        else $error("restart item produced a result");

    // Seeding passes are counted only while an item is in work.
    a_seed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (seed_rem_reg == '0))
        else $error("seeding count left over in idle");

    // A sample item consumes the pending seeding.
    a_first_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && !restart) |=> !first_pending_reg)
        else $error("seeding still pending after a sample item");

    // A finished result waits while the output register is still occupied.
    a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && filt_valid && filt_stall) |=> (state_reg == ST_HOLD))
        else $error("result overwrote an untaken output");

endmodule
